>>> rtl/core/sensor_channel_statistics_top_assert.svh
// assertion macros used by the port-level checker
`ifndef SENSOR_CHANNEL_STATISTICS_TOP_ASSERT_SVH
`define SENSOR_CHANNEL_STATISTICS_TOP_ASSERT_SVH

// same-cycle implication
`define SCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scs assertion failed");

// next-cycle implication
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scs assertion failed");

`endif

>>> rtl/core/scs_pkg.sv
// shared types and constants of the sensor channel statistics block
package scs_pkg;

	localparam int SUM_BITS      = 32;
	localparam int IN_DATA_BITS  = 16;
	localparam int IN_USER_BITS  = 3;
	localparam int OUT_DATA_BITS = 88;
	localparam int CFG_ADDR_BITS = 5;
	localparam int CFG_DATA_BITS = 32;
	localparam int LIMIT_BITS    = 16;

	localparam logic [LIMIT_BITS-1:0] TEMP_RANGE_RESET = 16'd4;
	localparam logic [LIMIT_BITS-1:0] AIR_LOW_RESET    = 16'd52;
	localparam logic [LIMIT_BITS-1:0] AIR_HIGH_RESET   = 16'd68;
	localparam logic [LIMIT_BITS-1:0] POWER_LOW_RESET  = 16'd200;
	localparam logic [LIMIT_BITS-1:0] POWER_HIGH_RESET = 16'd282;

	typedef enum logic [2:0] {
		REG_TEMP_RANGE = 3'd0,
		REG_AIR_LOW    = 3'd1,
		REG_AIR_HIGH   = 3'd2,
		REG_POWER_LOW  = 3'd3,
		REG_POWER_HIGH = 3'd4
	} reg_index_t;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_QUERY = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		CH_TEMP  = 2'd0,
		CH_AIR   = 2'd1,
		CH_POWER = 2'd2
	} channel_t;

	typedef enum logic [1:0] {
		CLS_LOW_STABLE        = 2'd0,
		CLS_MODERATE          = 2'd1,
		CLS_ELEVATED_VARIABLE = 2'd2,
		CLS_NO_DATA           = 2'd3
	} level_class_t;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] temp_range;
		logic [LIMIT_BITS-1:0] air_low;
		logic [LIMIT_BITS-1:0] air_high;
		logic [LIMIT_BITS-1:0] power_low;
		logic [LIMIT_BITS-1:0] power_high;
	} limits_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> rtl/core/sensor_channel_statistics_top.sv
// top level of the sensor channel statistics block
//
// channel   direction  transaction
// s_*       in         command and channel in tuser, sample in tdata
// m_*       out        count, latest, min, max, average and class in tdata
// apb       in/out     limit registers at byte addresses 0, 4, 8, 12, 16
//
// an item passes read, modify-write, 32 steps of the bit-serial divider, a wait
// for its done flag, then the result load once the output register is free;
// the next transaction is taken in the cycle after the result load
// a query to an empty channel or any item to an absent channel skips the divider
// statistics live in one ram, one record per channel; per-channel valid
// flops cleared by reset make every record read as zero until first written
// a new item is taken while a finished result waits in the output register
module sensor_channel_statistics_top
	import scs_pkg::*;
#(
	parameter int CHANNELS   = 3,
	parameter int VALUE_BITS = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,  // sample_value
	input  logic [IN_USER_BITS-1:0]  s_tuser,  // command, channel
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// sample_count, latest_value, minimum_value, maximum_value,
	// average_value, level_class, zero pad
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int ADDR_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int REC_BITS  = COUNT_BITS + 3 * VALUE_BITS + SUM_BITS;
	localparam int LAT_LO    = COUNT_BITS;
	localparam int MIN_LO    = LAT_LO + VALUE_BITS;
	localparam int MAX_LO    = MIN_LO + VALUE_BITS;
	localparam int SUM_LO    = MAX_LO + VALUE_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SUM_BITS-1:0] VALUE_MASK =
		SUM_BITS'((64'd1 << VALUE_BITS) - 64'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MODIFY,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t                   state_q;
	logic                     m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] m_tdata_q;
	logic                     empty_q;

	logic                     cmd_q;
	logic [1:0]               ch_q;
	logic [VALUE_BITS-1:0]    val_q;
	logic                     in_range_q;
	logic [CHANNELS-1:0]      valid_q;

	logic [COUNT_BITS-1:0]    cnt_q;
	logic [VALUE_BITS-1:0]    lat_q;
	logic [VALUE_BITS-1:0]    min_q;
	logic [VALUE_BITS-1:0]    max_q;

	limits_t                  limits;
	div_status_t              div_stat;
	logic [SUM_BITS-1:0]      quotient;

	logic                     in_acc;
	logic [IN_DATA_BITS+SUM_BITS-1:0] val_wide;
	logic [ADDR_BITS+1:0]     ch_wide;
	logic [ADDR_BITS-1:0]     addr;
	logic                     ram_rd_en;
	logic                     ram_wr_en;
	logic [REC_BITS-1:0]      rd_rec;
	logic [REC_BITS-1:0]      old_rec;
	logic [REC_BITS-1:0]      new_rec;

	logic [COUNT_BITS-1:0]    old_cnt;
	logic [VALUE_BITS-1:0]    old_lat;
	logic [VALUE_BITS-1:0]    old_min;
	logic [VALUE_BITS-1:0]    old_max;
	logic [SUM_BITS-1:0]      old_sum;
	logic [COUNT_BITS-1:0]    new_cnt;
	logic [VALUE_BITS-1:0]    new_lat;
	logic [VALUE_BITS-1:0]    new_min;
	logic [VALUE_BITS-1:0]    new_max;
	logic [SUM_BITS-1:0]      new_sum;
	logic [SUM_BITS:0]        sum_ext;
	logic                     do_add;
	logic                     acc_ok;
	logic                     new_empty;
	logic                     div_start;

	logic [VALUE_BITS-1:0]    spread;
	logic [LIMIT_BITS-1:0]    lo_lim;
	logic [LIMIT_BITS-1:0]    hi_lim;
	level_class_t             cls;
	logic [SUM_BITS-1:0]      cnt_w;
	logic [SUM_BITS-1:0]      lat_w;
	logic [SUM_BITS-1:0]      min_w;
	logic [SUM_BITS-1:0]      max_w;
	logic [SUM_BITS-1:0]      avg_w;
	logic                     out_free;
	logic                     out_load;

	scs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limits  (limits)
	);

	scs_ram #(
		.WIDTH (REC_BITS),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (addr),
		.wr_data (new_rec),
		.rd_en   (ram_rd_en),
		.rd_addr (addr),
		.rd_data (rd_rec)
	);

	scs_div #(
		.DIVISOR_BITS (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_sum),
		.divisor  (new_cnt),
		.quotient (quotient),
		.status   (div_stat)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign val_wide = {{SUM_BITS{1'b0}}, s_tdata};
	assign ch_wide  = {{ADDR_BITS{1'b0}}, ch_q};
	assign addr     = ch_wide[ADDR_BITS-1:0];
	assign ram_rd_en = (state_q == ST_READ);

	// input capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q      <= s_tuser[0];
			ch_q       <= s_tuser[2:1];
			val_q      <= val_wide[VALUE_BITS-1:0];
			in_range_q <= 32'(s_tuser[2:1]) < 32'(CHANNELS);
		end
	end

	// read-modify-write of one channel record
	assign old_rec = (in_range_q && valid_q[addr]) ? rd_rec : '0;
	assign old_cnt = old_rec[COUNT_BITS-1:0];
	assign old_lat = old_rec[MIN_LO-1:LAT_LO];
	assign old_min = old_rec[MAX_LO-1:MIN_LO];
	assign old_max = old_rec[SUM_LO-1:MAX_LO];
	assign old_sum = old_rec[REC_BITS-1:SUM_LO];

	assign do_add  = in_range_q && (command_t'(cmd_q) == CMD_ADD);
	assign sum_ext = (SUM_BITS+1)'(old_sum) + (SUM_BITS+1)'(val_q);
	assign acc_ok  = (old_cnt != COUNT_MAX) && !sum_ext[SUM_BITS];

	always_comb begin
		new_cnt = old_cnt;
		new_lat = old_lat;
		new_min = old_min;
		new_max = old_max;
		new_sum = old_sum;
		if (do_add) begin
			new_lat = val_q;
			if (old_cnt == '0) begin
				new_min = val_q;
				new_max = val_q;
			end else begin
				if (val_q < old_min) begin
					new_min = val_q;
				end
				if (val_q > old_max) begin
					new_max = val_q;
				end
			end
			if (acc_ok) begin
				new_cnt = old_cnt + 1'b1;
				new_sum = sum_ext[SUM_BITS-1:0];
			end
		end
	end

	assign new_rec   = {new_sum, new_max, new_min, new_lat, new_cnt};
	assign ram_wr_en = (state_q == ST_MODIFY) && do_add;
	assign new_empty = !in_range_q || (new_cnt == '0);
	assign div_start = (state_q == ST_MODIFY) && !new_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_wr_en) begin
			valid_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MODIFY) begin
			cnt_q <= new_cnt;
			lat_q <= new_lat;
			min_q <= new_min;
			max_q <= new_max;
		end
	end

	// classification and result formatting
	assign spread = max_q - min_q;
	assign cnt_w  = SUM_BITS'(cnt_q);
	assign lat_w  = SUM_BITS'(lat_q);
	assign min_w  = SUM_BITS'(min_q);
	assign max_w  = SUM_BITS'(max_q);
	assign avg_w  = quotient & VALUE_MASK;

	always_comb begin
		if (channel_t'(ch_q) == CH_AIR) begin
			lo_lim = limits.air_low;
			hi_lim = limits.air_high;
		end else begin
			lo_lim = limits.power_low;
			hi_lim = limits.power_high;
		end
		priority if (channel_t'(ch_q) == CH_TEMP) begin
			cls = (SUM_BITS'(spread) <= SUM_BITS'(limits.temp_range)) ?
				CLS_LOW_STABLE : CLS_ELEVATED_VARIABLE;
		end else if (quotient < SUM_BITS'(lo_lim)) begin
			cls = CLS_LOW_STABLE;
		end else if (quotient < SUM_BITS'(hi_lim)) begin
			cls = CLS_MODERATE;
		end else begin
			cls = CLS_ELEVATED_VARIABLE;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			empty_q    <= 1'b1;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MODIFY;
				end
				ST_MODIFY: begin
					empty_q <= new_empty;
					state_q <= new_empty ? ST_FINISH : ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_stat.done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (empty_q) begin
							m_tdata_q <= {6'd0, CLS_NO_DATA, 80'd0};
						end else begin
							m_tdata_q <= {6'd0, cls, avg_w[15:0], max_w[15:0],
								min_w[15:0], lat_w[15:0], cnt_w[15:0]};
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/core/scs_ram.sv
// generic single-port-write ram with registered read
module scs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/scs_div.sv
// restoring divider, one quotient bit per cycle
module scs_div
	import scs_pkg::*;
#(
	parameter int DIVISOR_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [SUM_BITS-1:0]     dividend,
	input  logic [DIVISOR_BITS-1:0] divisor,
	output logic [SUM_BITS-1:0]     quotient,
	output div_status_t             status
);

	localparam int STEP_BITS = $clog2(SUM_BITS);

	logic [SUM_BITS-1:0]     quo_q;
	logic [DIVISOR_BITS-1:0] rem_q;
	logic [DIVISOR_BITS-1:0] dsr_q;
	logic [STEP_BITS-1:0]    step_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIVISOR_BITS:0]   rem_sh;
	logic [DIVISOR_BITS:0]   rem_diff;
	logic                    fits;

	assign rem_sh   = {rem_q, quo_q[SUM_BITS-1]};
	assign rem_diff = rem_sh - {1'b0, dsr_q};
	assign fits     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(SUM_BITS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
			rem_q <= fits ? rem_diff[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> rtl/core/scs_cfg.sv
// apb register file for the classification limits
module scs_cfg
	import scs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output limits_t                  limits
);

	limits_t    limits_q;
	reg_index_t reg_idx;
	logic       wr_en;

	assign reg_idx = reg_index_t'(paddr[CFG_ADDR_BITS-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.temp_range <= TEMP_RANGE_RESET;
			limits_q.air_low    <= AIR_LOW_RESET;
			limits_q.air_high   <= AIR_HIGH_RESET;
			limits_q.power_low  <= POWER_LOW_RESET;
			limits_q.power_high <= POWER_HIGH_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TEMP_RANGE: limits_q.temp_range <= pwdata[LIMIT_BITS-1:0];
				REG_AIR_LOW:    limits_q.air_low    <= pwdata[LIMIT_BITS-1:0];
				REG_AIR_HIGH:   limits_q.air_high   <= pwdata[LIMIT_BITS-1:0];
				REG_POWER_LOW:  limits_q.power_low  <= pwdata[LIMIT_BITS-1:0];
				REG_POWER_HIGH: limits_q.power_high <= pwdata[LIMIT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TEMP_RANGE: prdata = CFG_DATA_BITS'(limits_q.temp_range);
			REG_AIR_LOW:    prdata = CFG_DATA_BITS'(limits_q.air_low);
			REG_AIR_HIGH:   prdata = CFG_DATA_BITS'(limits_q.air_high);
			REG_POWER_LOW:  prdata = CFG_DATA_BITS'(limits_q.power_low);
			REG_POWER_HIGH: prdata = CFG_DATA_BITS'(limits_q.power_high);
			default:        prdata = '0;
		endcase
	end

	assign limits = limits_q;

endmodule

>>> rtl/core/scs_checker.sv
// port-level checker for the sensor channel statistics block
`include "sensor_channel_statistics_top_assert.svh"

module scs_port_checker
	import scs_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata
);

	logic [15:0] cnt;
	logic [15:0] lat;
	logic [15:0] mn;
	logic [15:0] mx;
	logic [15:0] avg;
	logic [1:0]  cls;
	logic        out_stall;
	logic        in_acc;
	logic        no_data;
	logic        has_data;
	logic        stats_ok;

	assign cnt = m_tdata[15:0];
	assign lat = m_tdata[31:16];
	assign mn  = m_tdata[47:32];
	assign mx  = m_tdata[63:48];
	assign avg = m_tdata[79:64];
	assign cls = m_tdata[81:80];

	assign out_stall = m_tvalid && !m_tready;
	assign in_acc    = s_tvalid && s_tready;
	assign no_data   = m_tvalid && (cls == CLS_NO_DATA);
	assign has_data  = m_tvalid && (cls != CLS_NO_DATA);
	assign stats_ok  = (cnt != 16'd0) && (mn <= lat) && (lat <= mx) && (mn <= avg) &&
		(avg <= mx);

	`SCS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata))
	`SCS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_acc, !s_tready)
	`SCS_ASSERT_IMPLY(a_nodata_zero, clk, arst_n, no_data, m_tdata[79:0] == 80'd0)
	`SCS_ASSERT_IMPLY(a_stats_order, clk, arst_n, has_data, stats_ok)

endmodule

bind sensor_channel_statistics_top scs_port_checker u_scs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> bench/scs_checker.sv
// checker for the sensor channel statistics block: watches all channels, predicts and compares results
`timescale 1ns / 100ps

module scs_checker
	import scs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	input  logic [IN_USER_BITS-1:0]  s_tuser,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output int                       mismatches,
	output int                       outstanding
);

	localparam int N_CH = 3;

	typedef struct {
		logic [15:0]  count;
		logic [15:0]  latest;
		logic [15:0]  minv;
		logic [15:0]  maxv;
		logic [15:0]  avg;
		level_class_t cls;
	} chan_stats_t;

	logic [15:0] count_q  [N_CH];
	logic [15:0] latest_q [N_CH];
	logic [15:0] min_q    [N_CH];
	logic [15:0] max_q    [N_CH];
	logic [31:0] sum_q    [N_CH];
	limits_t     lim;
	chan_stats_t stats_q [$];

	function automatic level_class_t grade(input logic [15:0] avg, input logic [15:0] lo,
			input logic [15:0] hi);
		if (avg < lo)
			return CLS_LOW_STABLE;
		if (avg < hi)
			return CLS_MODERATE;
		return CLS_ELEVATED_VARIABLE;
	endfunction

	// folds one transaction into the channel state and returns the channel statistics
	function automatic chan_stats_t fold_sample(input command_t cmd, input logic [1:0] ch,
			input logic [15:0] val);
		chan_stats_t r;
		logic [32:0] grown;
		r.count  = '0;
		r.latest = '0;
		r.minv   = '0;
		r.maxv   = '0;
		r.avg    = '0;
		r.cls    = CLS_NO_DATA;
		if (ch >= N_CH)
			return r;
		if (cmd == CMD_ADD) begin
			if (count_q[ch] == 0) begin
				min_q[ch] = val;
				max_q[ch] = val;
			end else begin
				if (val < min_q[ch])
					min_q[ch] = val;
				if (val > max_q[ch])
					max_q[ch] = val;
			end
			latest_q[ch] = val;
			grown = {1'b0, sum_q[ch]} + {17'd0, val};
			if (count_q[ch] != 16'hFFFF && !grown[32]) begin
				count_q[ch] = count_q[ch] + 16'd1;
				sum_q[ch]   = grown[31:0];
			end
		end
		if (count_q[ch] == 0)
			return r;
		r.count  = count_q[ch];
		r.latest = latest_q[ch];
		r.minv   = min_q[ch];
		r.maxv   = max_q[ch];
		r.avg    = 16'(sum_q[ch] / {16'd0, count_q[ch]});
		if (ch == CH_TEMP)
			r.cls = (max_q[ch] - min_q[ch] <= lim.temp_range) ? CLS_LOW_STABLE
				: CLS_ELEVATED_VARIABLE;
		else if (ch == CH_AIR)
			r.cls = grade(r.avg, lim.air_low, lim.air_high);
		else
			r.cls = grade(r.avg, lim.power_low, lim.power_high);
		return r;
	endfunction

	task automatic note_field(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want_v,
					got_v);
		end
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin : watch
		chan_stats_t want;
		chan_stats_t got;
		int i;
		if (!arst_n) begin
			for (i = 0; i < N_CH; i++) begin
				count_q[i]  = '0;
				latest_q[i] = '0;
				min_q[i]    = '0;
				max_q[i]    = '0;
				sum_q[i]    = '0;
			end
			lim.temp_range = TEMP_RANGE_RESET;
			lim.air_low    = AIR_LOW_RESET;
			lim.air_high   = AIR_HIGH_RESET;
			lim.power_low  = POWER_LOW_RESET;
			lim.power_high = POWER_HIGH_RESET;
			stats_q.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[4:2]))
					REG_TEMP_RANGE: lim.temp_range = pwdata[15:0];
					REG_AIR_LOW:    lim.air_low    = pwdata[15:0];
					REG_AIR_HIGH:   lim.air_high   = pwdata[15:0];
					REG_POWER_LOW:  lim.power_low  = pwdata[15:0];
					REG_POWER_HIGH: lim.power_high = pwdata[15:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.count  = m_tdata[15:0];
				got.latest = m_tdata[31:16];
				got.minv   = m_tdata[47:32];
				got.maxv   = m_tdata[63:48];
				got.avg    = m_tdata[79:64];
				got.cls    = level_class_t'(m_tdata[81:80]);
				if (stats_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transaction with nothing expected", $realtime);
				end else begin
					want = stats_q.pop_front();
					note_field("sample_count", want.count, got.count);
					note_field("latest_value", want.latest, got.latest);
					note_field("minimum_value", want.minv, got.minv);
					note_field("maximum_value", want.maxv, got.maxv);
					note_field("average_value", want.avg, got.avg);
					note_field("level_class", 16'(want.cls), 16'(got.cls));
				end
			end
			if (s_tvalid && s_tready)
				stats_q.push_back(fold_sample(command_t'(s_tuser[0]), s_tuser[2:1], s_tdata));
			outstanding <= stats_q.size();
		end
	end

endmodule

>>> bench/tb.sv
// testbench top for the sensor channel statistics block: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps

module tb;
	import scs_pkg::*;

	localparam logic [1:0] CH_ABSENT  = 2'd3;
	localparam int         LAST_PHASE = 5;
	localparam int         PHASE_ITEMS = 90;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
	logic [IN_USER_BITS-1:0]  s_tuser  = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     psel     = 1'b0;
	logic                     penable  = 1'b0;
	logic                     pwrite   = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr    = '0;
	logic [CFG_DATA_BITS-1:0] pwdata   = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	int mismatches;
	int outstanding;
	bit calm      = 1'b0;
	bit long_hold = 1'b0;

	always #6 clk = ~clk;

	sensor_channel_statistics_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	scs_checker stats_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	task automatic send_item(input command_t cmd, input logic [1:0] ch,
			input logic [15:0] val);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= {ch, cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_limit(input reg_index_t idx, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_limits(input logic [15:0] t, input logic [15:0] al,
			input logic [15:0] ah, input logic [15:0] pl, input logic [15:0] ph);
		write_limit(REG_TEMP_RANGE, t);
		write_limit(REG_AIR_LOW, al);
		write_limit(REG_AIR_HIGH, ah);
		write_limit(REG_POWER_LOW, pl);
		write_limit(REG_POWER_HIGH, ph);
	endtask

	// stop offering and wait for every result before touching the limits
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int phase);
		command_t    cmd;
		logic [1:0]  ch;
		logic [15:0] val;
		int          k;
		int          pick;
		for (k = 0; k < n; k++) begin
			calm = (phase == LAST_PHASE) && (k >= n - 60);
			cmd  = ($urandom_range(0, 3) == 0) ? CMD_QUERY : CMD_ADD;
			ch   = ($urandom_range(0, 15) == 0) ? CH_ABSENT : 2'($urandom_range(0, 2));
			pick = $urandom_range(0, 39);
			if (ch == CH_TEMP)
				val = 16'($urandom_range(20, 40));
			else if (pick == 0)
				val = 16'hFFFF;
			else if (pick == 1)
				val = 16'h0000;
			else if (pick < 4)
				val = 16'($urandom);
			else
				val = 16'($urandom_range(0, 400));
			if (cmd == CMD_QUERY && pick[0])
				val = 16'($urandom);
			send_item(cmd, ch, val);
		end
	endtask

	initial begin : sink
		int   n;
		logic rdy;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				rdy = 1'b0;
				n = 300;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				rdy = 1'b0;
				n = $urandom_range(1, 7);
			end else begin
				rdy = 1'b1;
				n = $urandom_range(1, 12);
			end
			m_tready <= rdy;
			repeat (n) @(posedge clk);
		end
	end

	initial begin : stimulus
		int          phase;
		int          guard;
		logic [15:0] lo_a;
		logic [15:0] lo_p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty channels, absent channel, first sample, limit edges at reset values
		send_item(CMD_QUERY, CH_TEMP, 16'hFFFF);
		send_item(CMD_ADD, CH_ABSENT, 16'hFFFF);
		send_item(CMD_QUERY, CH_ABSENT, 16'h0000);
		send_item(CMD_QUERY, CH_AIR, 16'h1234);
		send_item(CMD_ADD, CH_TEMP, 16'd25);
		send_item(CMD_ADD, CH_TEMP, 16'd29);
		send_item(CMD_ADD, CH_TEMP, 16'd31);
		send_item(CMD_QUERY, CH_TEMP, 16'hABCD);
		send_item(CMD_ADD, CH_AIR, 16'h0000);
		send_item(CMD_ADD, CH_AIR, 16'hFFFF);
		send_item(CMD_ADD, CH_AIR, 16'd52);
		send_item(CMD_ADD, CH_POWER, 16'd199);
		send_item(CMD_QUERY, CH_POWER, 16'hFFFF);
		send_item(CMD_ADD, CH_POWER, 16'd201);
		send_item(CMD_ADD, CH_POWER, 16'd481);
		send_item(CMD_ADD, CH_POWER, 16'd0);
		send_item(CMD_ADD, CH_ABSENT, 16'h5555);
		send_item(CMD_QUERY, CH_AIR, 16'h0000);
		send_item(CMD_ADD, CH_TEMP, 16'd27);
		send_item(CMD_ADD, CH_AIR, 16'h8000);
		send_item(CMD_ADD, CH_TEMP, 16'd26);

		for (phase = 1; phase <= LAST_PHASE; phase++) begin
			settle();
			case (phase)
				1: program_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
				2: program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: begin
					// high limit at or below the low limit
					lo_a = 16'($urandom_range(100, 1500));
					lo_p = 16'($urandom_range(100, 1500));
					program_limits(16'($urandom_range(0, 30)), lo_a,
						16'($urandom_range(0, lo_a)), lo_p, 16'($urandom_range(0, lo_p)));
				end
				4: begin
					lo_a = 16'($urandom_range(0, 1500));
					lo_p = 16'($urandom_range(0, 1500));
					program_limits(16'($urandom_range(0, 30)), lo_a,
						lo_a + 16'($urandom_range(1, 500)), lo_p,
						lo_p + 16'($urandom_range(1, 500)));
				end
				default: program_limits(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			endcase
			if (phase == 2)
				long_hold = 1'b1;
			run_random(PHASE_ITEMS, phase);
		end

		s_tvalid <= 1'b0;
		guard = 0;
		@(posedge clk);
		while (outstanding != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("sensor_channel_statistics_top verification clean");
		else
			$display("sensor_channel_statistics_top verification failed");
		$finish;
	end

	initial begin : watchdog
		#2400000;
		$display("sensor_channel_statistics_top verification failed");
		$finish;
	end

endmodule
